/* src/dfr_pkg.sv */
// ----------------------------------------------------------------------------
// dfr_pkg: shared types, constants and helpers for the delta regression block
// Payload structs, the job descriptor passed from front to back, the window
// geometry and the regression denominator table.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  localparam int MAX_HALF_WIDTH = 8;
  localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1;
  localparam int IDX_W          = $clog2(WIN_DEPTH + 1);
  localparam int HALF_W         = 4;
  localparam int SAMPLE_W       = 16;
  localparam int ACC_W          = 24;   // |sum i*diff| < 2^22
  localparam int DVD_W          = 23;   // 2*|num| + D
  localparam int DEN_W          = 9;    // D up to 408
  localparam int DIV_W          = DEN_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [HALF_W-1:0] half_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_row;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] delta_value;
    logic                       row_done;
    logic                       last_of_run;
  } result_t;

  // One delta computation, emitted copies times.
  typedef struct packed {
    idx_t  t;
    idx_t  n;
    half_t h;
    idx_t  base;
    idx_t  copies;
    logic  done;
    logic  last;
  } job_t;

  function automatic half_t eff_half(input half_t raw);
    half_t h;
    h = raw;
    if (raw == '0) h = half_t'(1);
    else if (raw > half_t'(MAX_HALF_WIDTH)) h = half_t'(MAX_HALF_WIDTH);
    return h;
  endfunction

  // D = h(h+1)(2h+1)/3
  function automatic logic [DEN_W-1:0] denom_of(input half_t h);
    logic [DEN_W-1:0] d;
    unique case (h)
      4'd1:    d = 9'd2;
      4'd2:    d = 9'd10;
      4'd3:    d = 9'd28;
      4'd4:    d = 9'd60;
      4'd5:    d = 9'd110;
      4'd6:    d = 9'd182;
      4'd7:    d = 9'd280;
      4'd8:    d = 9'd408;
      default: d = 9'd2;
    endcase
    return d;
  endfunction

  // Circular window index: (a + b) mod WIN_DEPTH, both below WIN_DEPTH.
  function automatic idx_t wrap_add(input idx_t a, input idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(WIN_DEPTH)) s = s - (IDX_W+1)'(WIN_DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/delta_feature_regression.sv */
// ----------------------------------------------------------------------------
// delta_feature_regression: streaming delta (regression slope) of a feature row
// Samples in Q7.8 go in frame by frame; deltas over a 2h+1 frame window come
// out in frame order, rounded to nearest and saturated to Q7.8.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              transaction
//   item      in         item_valid/item_ready  one sample + end_of_row flag
//   result    out        result_valid/ready     one delta + row_done/last_of_run
//   apb       in/out     psel/penable/pready    half-width register write/read
//
// Back end: each delta passes through a pop state, h taps of the
// multiply-accumulate, a drain and a setup state, the one-bit-per-cycle
// divider and a load state; the result is then shown once per emitted copy.
// A new sample is taken once the previous one's jobs have left the queue and
// the back end is no longer reading the window.
// Reset (rst, synchronous, high) empties the row and sets the half width to 4.
// Either side may stall: the job queue and the result register decouple them.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_feature_regression (
  input  wire logic              clk,
  input  wire logic              rst,
  // sample stream
  input  wire dfr_pkg::item_t    item,
  input  wire logic              item_valid,
  output logic                   item_ready,
  // delta stream
  output dfr_pkg::result_t       result,
  output logic                   result_valid,
  input  wire logic              result_ready,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import dfr_pkg::*;

  localparam logic REG_HALF_WIDTH = 1'b0;   // word index of the half-width register

  half_t         half_cfg;
  job_t          push_job;
  job_t          head;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  logic          back_reading;
  logic          wr_en;
  idx_t          wr_addr;
  logic signed [15:0] wr_data;
  idx_t          rd_addr_a;
  idx_t          rd_addr_b;
  logic signed [15:0] rd_data_a;
  logic signed [15:0] rd_data_b;

  // Register file: one register, raw 4-bit value; clamping happens at row start.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HALF_WIDTH) ? {28'd0, half_cfg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_cfg <= half_t'(4);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_WIDTH) begin
      half_cfg <= pwdata[HALF_W-1:0];
    end
  end

  // Front: classify each sample, update the window, post jobs.
  dfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .half_cfg     (half_cfg),
    .back_reading (back_reading),
    .q_empty      (q_empty),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // Window samples, read by the back end two taps per cycle.
  dfr_window u_window (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  dfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: MAC, divide, round/saturate, emit.
  dfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b),
    .reading      (back_reading),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire

/* src/dfr_window.sv */
// ----------------------------------------------------------------------------
// dfr_window: sample window storage
// Circular store of the row's recent samples, one write and two read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_window (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire dfr_pkg::idx_t        wr_addr,
  input  wire logic signed [15:0]   wr_data,
  input  wire dfr_pkg::idx_t        rd_addr_a,
  input  wire dfr_pkg::idx_t        rd_addr_b,
  output logic signed [15:0]        rd_data_a,
  output logic signed [15:0]        rd_data_b
);
  import dfr_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

/* src/dfr_queue.sv */
// ----------------------------------------------------------------------------
// dfr_queue: job queue
// Two-entry FIFO of job descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire dfr_pkg::job_t push_job,
  input  wire logic          pop,
  output dfr_pkg::job_t      head,
  output logic               empty,
  output logic               full
);
  import dfr_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/dfr_front.sv */
// ----------------------------------------------------------------------------
// dfr_front: input side
// Takes samples, tracks row fill and window position, writes the window and
// turns each sample into delta jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dfr_pkg::item_t item,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire dfr_pkg::half_t half_cfg,
  input  wire logic           back_reading,
  input  wire logic           q_empty,
  input  wire logic           q_full,
  output logic                push,
  output dfr_pkg::job_t       push_job,
  output logic                wr_en,
  output dfr_pkg::idx_t       wr_addr,
  output logic signed [15:0]  wr_data
);
  import dfr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ONE  = 2'd1;
  localparam logic [1:0] F_GEN  = 2'd2;

  logic [1:0] state;
  idx_t       fs;
  half_t      row_h;
  idx_t       base;
  job_t       job;
  idx_t       gen_t;
  idx_t       gen_n;

  half_t h_cur;
  idx_t  h5;
  idx_t  w;
  idx_t  fs_next;
  idx_t  extra;
  logic  filling;
  logic  accept;
  logic  gen_last;
  job_t  gen_job;

  always_comb begin
    h_cur    = (fs == '0) ? eff_half(half_cfg) : row_h;
    h5       = {1'b0, h_cur};
    w        = {h_cur, 1'b1};
    fs_next  = fs + idx_t'(1);
    filling  = (fs < w);
    extra    = item.end_of_row ? h5 : '0;
    accept   = item_valid && item_ready;
    gen_last = (gen_t == gen_n - idx_t'(1));
    gen_job  = '{t: gen_t, n: gen_n, h: row_h, base: '0, copies: idx_t'(1),
                 done: gen_last, last: gen_last};
  end

  assign item_ready = (state == F_IDLE) && q_empty && !back_reading;
  assign wr_en      = accept;
  assign wr_data    = item.sample;
  assign wr_addr    = filling ? wrap_add(base, fs) : wrap_add(base, w);
  assign push       = ((state == F_ONE) || (state == F_GEN)) && !q_full;
  assign push_job   = (state == F_ONE) ? job : gen_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      fs    <= '0;
      row_h <= half_t'(1);
      base  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            row_h <= h_cur;
            if (filling) begin
              // base stays at zero while a row fills
              fs <= item.end_of_row ? '0 : fs_next;
              if (fs_next == w) begin
                job   <= '{t: h5, n: w, h: h_cur, base: base,
                           copies: h5 + idx_t'(1) + extra,
                           done: item.end_of_row, last: 1'b1};
                state <= F_ONE;
              end else if (item.end_of_row) begin
                gen_t <= '0;
                gen_n <= fs_next;
                state <= F_GEN;
              end
            end else begin
              if (item.end_of_row) fs <= '0;
              base  <= item.end_of_row ? '0 : wrap_add(base, idx_t'(1));
              job   <= '{t: h5, n: w, h: h_cur, base: wrap_add(base, idx_t'(1)),
                         copies: idx_t'(1) + extra,
                         done: item.end_of_row, last: 1'b1};
              state <= F_ONE;
            end
          end
        end
        F_ONE: begin
          if (!q_full) state <= F_IDLE;
        end
        F_GEN: begin
          if (!q_full) begin
            gen_t <= gen_t + idx_t'(1);
            if (gen_last) state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/dfr_back.sv */
// ----------------------------------------------------------------------------
// dfr_back: delta engine
// Per job: walks the window pairs with one multiply-accumulate per cycle,
// divides by twice the regression denominator one bit per cycle, rounds,
// saturates and emits the result the requested number of times.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dfr_pkg::job_t    head,
  input  wire logic             q_empty,
  output logic                  pop,
  output dfr_pkg::idx_t         rd_addr_a,
  output dfr_pkg::idx_t         rd_addr_b,
  input  wire logic signed [15:0] rd_data_a,
  input  wire logic signed [15:0] rd_data_b,
  output logic                  reading,
  output dfr_pkg::result_t      result,
  output logic                  result_valid,
  input  wire logic             result_ready
);
  import dfr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]              state;
  job_t                    job;
  half_t                   step;
  half_t                   mac_step;
  logic                    mac_vld;
  logic signed [ACC_W-1:0] acc;
  logic [DIV_W-1:0]        rem;
  logic [DVD_W-1:0]        quo;
  logic [4:0]              div_cnt;
  logic                    neg;
  idx_t                    copies_left;
  logic signed [15:0]      value;

  logic [IDX_W:0]          t_plus;
  idx_t                    hi;
  idx_t                    lo;
  logic signed [16:0]      diff;
  logic signed [21:0]      prod;
  logic [ACC_W-1:0]        mag;
  logic [DEN_W-1:0]        den;
  logic [DVD_W-1:0]        dvd;
  logic [DIV_W-1:0]        div2;
  logic [DIV_W:0]          trial;
  logic                    ge;
  logic [DIV_W:0]          trial_sub;
  logic [15:0]             sat;

  always_comb begin
    t_plus = {1'b0, job.t} + (IDX_W+1)'(step);
    hi     = (t_plus < {1'b0, job.n}) ? t_plus[IDX_W-1:0] : job.n - idx_t'(1);
    lo     = (job.t >= idx_t'(step)) ? job.t - idx_t'(step) : '0;
    diff   = {rd_data_a[15], rd_data_a} - {rd_data_b[15], rd_data_b};
    prod   = $signed({1'b0, mac_step}) * diff;
    mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    den    = denom_of(job.h);
    dvd    = {mag[DVD_W-2:0], 1'b0} + DVD_W'(den);
    div2   = {den, 1'b0};
    trial  = {rem, quo[DVD_W-1]};
    ge     = (trial >= {1'b0, div2});
    trial_sub = trial - {1'b0, div2};
    if (!neg) begin
      sat = (quo > DVD_W'(32767)) ? 16'h7fff : quo[15:0];
    end else begin
      sat = (quo > DVD_W'(32768)) ? 16'h8000 : (~quo[15:0] + 16'd1);
    end
  end

  assign rd_addr_a    = wrap_add(job.base, hi);
  assign rd_addr_b    = wrap_add(job.base, lo);
  assign reading      = (state == S_MAC);
  assign pop          = (state == S_IDLE) && !q_empty;
  assign result_valid = (state == S_OUT);

  always_comb begin
    result.delta_value = value;
    result.row_done    = (copies_left == idx_t'(1)) && job.done;
    result.last_of_run = (copies_left == idx_t'(1)) && job.last;
  end

  always_ff @(posedge clk) begin
    mac_step <= step;
    if (mac_vld) acc <= acc + ACC_W'(prod);
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          job  <= head;
          step <= half_t'(1);
          acc  <= '0;
        end
      end
      S_MAC:  step <= step + half_t'(1);
      S_PREP: begin
        rem     <= '0;
        quo     <= dvd;
        neg     <= acc[ACC_W-1];
        div_cnt <= '0;
      end
      S_DIV: begin
        rem     <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        quo     <= {quo[DVD_W-2:0], ge};
        div_cnt <= div_cnt + 5'd1;
      end
      S_LOAD: value <= sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mac_vld     <= 1'b0;
      copies_left <= '0;
    end else begin
      mac_vld <= (state == S_MAC);
      unique case (state)
        S_IDLE:  if (!q_empty) state <= S_MAC;
        S_MAC:   if (step == job.h) state <= S_DRAIN;
        S_DRAIN: state <= S_PREP;
        S_PREP:  state <= S_DIV;
        S_DIV:   if (div_cnt == 5'(DVD_W - 1)) state <= S_LOAD;
        S_LOAD: begin
          copies_left <= job.copies;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (result_ready) begin
            copies_left <= copies_left - idx_t'(1);
            if (copies_left == idx_t'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_has_copies: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (copies_left != '0))
    else $error("result shown with no copies left");

  a_prep_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |=> (state == S_DIV))
    else $error("divider not started after prep");

  a_mac_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (step != '0 && step <= job.h))
    else $error("tap index out of window");

endmodule

`default_nettype wire
